/* hw/rtl/dbnc_pkg.sv */
// shared types, field widths and register indexes for the input debouncer core
// no dependencies; imported by every module of the block

package dbnc_pkg;

    // fixed sizes of the block
    localparam int NUM_CHANNELS = 16;
    localparam int ADC_BITS     = 12;
    localparam int CH_W         = 4;
    localparam int CNT_W        = 8;
    localparam int MASK_W       = 16;
    localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INC_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_SRC_MASK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK  = 3'd6;

    // stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // configuration seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0]    inc_step;
        logic [CNT_W-1:0]    dec_step;
        logic [CNT_W-1:0]    threshold;
        logic [ADC_BITS-1:0] adc_high;
        logic [ADC_BITS-1:0] adc_low;
        logic [MASK_W-1:0]   adc_source_mask;
        logic [MASK_W-1:0]   active_level_mask;
    } cfg_t;

    // one per-channel state memory entry
    typedef struct packed {
        logic             last_adc_level;
        logic             filtered_bit;
        logic [CNT_W-1:0] step_count;
    } chan_state_t;

    // one sample entering the update stage
    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic                pin_level;
        logic [ADC_BITS-1:0] adc_value;
        logic                in_range;
    } sample_t;

    // one result item
    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic             filtered_level;
        logic             raw_level;
        logic [CNT_W-1:0] count_value;
    } result_t;

endpackage

/* hw/rtl/dbnc_cfg_regs.sv */
// configuration register file of the debouncer core
// depends on dbnc_pkg for the register indexes and cfg_t

module dbnc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dbnc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [dbnc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output dbnc_pkg::cfg_t                  cfg
);
    import dbnc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode a write; unknown indexes leave everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_INC_STEP:     cfg_next.inc_step          = cfg_wr_data[CNT_W-1:0];
                REG_DEC_STEP:     cfg_next.dec_step          = cfg_wr_data[CNT_W-1:0];
                REG_THRESHOLD:    cfg_next.threshold         = cfg_wr_data[CNT_W-1:0];
                REG_ADC_HIGH:     cfg_next.adc_high          = cfg_wr_data[ADC_BITS-1:0];
                REG_ADC_LOW:      cfg_next.adc_low           = cfg_wr_data[ADC_BITS-1:0];
                REG_ADC_SRC_MASK: cfg_next.adc_source_mask   = cfg_wr_data[MASK_W-1:0];
                REG_ACTIVE_MASK:  cfg_next.active_level_mask = cfg_wr_data[MASK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inc_step          <= CNT_W'(1);
            cfg_reg.dec_step          <= CNT_W'(1);
            cfg_reg.threshold         <= CNT_W'(5);
            cfg_reg.adc_high          <= ADC_BITS'(3000);
            cfg_reg.adc_low           <= ADC_BITS'(1000);
            cfg_reg.adc_source_mask   <= '0;
            cfg_reg.active_level_mask <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/dbnc_state_ram.sv */
// per-channel state memory: one write port, one registered read port
// valid bits in flops make entries read as zero until first written; uses dbnc_pkg

module dbnc_state_ram (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [dbnc_pkg::ADDR_W-1:0]  rd_addr,
    output dbnc_pkg::chan_state_t        rd_data,
    input  logic                         wr_en,
    input  logic [dbnc_pkg::ADDR_W-1:0]  wr_addr,
    input  dbnc_pkg::chan_state_t        wr_data
);
    import dbnc_pkg::*;

    chan_state_t             mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    chan_state_t             rd_q_reg;
    logic                    rd_valid_reg;

    // storage array and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // valid bits and the valid flag of the read in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

/* hw/rtl/dbnc_update.sv */
// state update for one sample: adc hysteresis, integrating counter, filtered bit
// depends on dbnc_pkg for cfg_t, sample_t, chan_state_t and result_t

module dbnc_update (
    input  dbnc_pkg::cfg_t        cfg,
    input  dbnc_pkg::sample_t     sample,
    input  dbnc_pkg::chan_state_t cur_state,
    output dbnc_pkg::chan_state_t new_state,
    output dbnc_pkg::result_t     result
);
    import dbnc_pkg::*;

    logic           use_adc;
    logic           active;
    logic           raw;
    logic [CNT_W:0] sum;

    always_comb begin
        use_adc = cfg.adc_source_mask[sample.channel];
        active  = cfg.active_level_mask[sample.channel];

        // raw level: adc hysteresis or the pin; high threshold tested first
        if (use_adc) begin
            if (sample.adc_value > cfg.adc_high) begin
                raw = 1'b1;
            end else if (sample.adc_value < cfg.adc_low) begin
                raw = 1'b0;
            end else begin
                raw = cur_state.last_adc_level;
            end
        end else begin
            raw = sample.pin_level;
        end

        new_state = cur_state;
        if (use_adc) begin
            new_state.last_adc_level = raw;
        end

        // integrating counter, sum formed one bit wider so it cannot wrap
        sum = {1'b0, cur_state.step_count} + {1'b0, cfg.inc_step};
        if (raw == active) begin
            if (sum >= {1'b0, cfg.threshold}) begin
                new_state.step_count   = cfg.threshold;
                new_state.filtered_bit = 1'b1;
            end else begin
                new_state.step_count = sum[CNT_W-1:0];
            end
        end else begin
            if (cur_state.step_count <= cfg.dec_step) begin
                new_state.step_count   = '0;
                new_state.filtered_bit = 1'b0;
            end else begin
                new_state.step_count = cur_state.step_count - cfg.dec_step;
            end
        end

        // result; a channel outside the table reports zeros
        result.out_channel = sample.channel;
        if (sample.in_range) begin
            result.filtered_level = new_state.filtered_bit;
            result.raw_level      = raw;
            result.count_value    = new_state.step_count;
        end else begin
            result.filtered_level = 1'b0;
            result.raw_level      = 1'b0;
            result.count_value    = '0;
        end
    end

endmodule

/* hw/rtl/multichannel_input_debouncer_core.sv */
// Multichannel input debouncer core: adc hysteresis and per-channel integrating counters.
// Pipeline: at accept the sample register is loaded and the state memory read; the update
// result enters the output register, raising m_axis_tvalid, as that stage advances. Throughput:
// one sample per cycle unless the output stalls; state is written back as the update stage
// advances, forwarding the last write. Reset: synchronous active-low aresetn restores register
// defaults and clears the state valid bits, so every channel starts at zero with no clearing pass.

module multichannel_input_debouncer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: [3:0] channel, [4] pin_level, [16:5] adc_value, rest zero
    input  logic [dbnc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: [3:0] out_channel, [4] filtered_level, [5] raw_level, [13:6] count_value,
    // rest zero
    output logic [dbnc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [dbnc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [dbnc_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import dbnc_pkg::*;

    localparam int NUM_CH_W = CH_W + 1;

    cfg_t        cfg;
    sample_t     in_sample;
    sample_t     s1_sample_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic        m_valid_reg, m_valid_next;
    result_t     m_result_reg;
    result_t     upd_result;
    chan_state_t ram_rd_data;
    chan_state_t cur_state;
    chan_state_t new_state;
    logic        wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    chan_state_t wb_data_reg;
    logic        s_xfer;
    logic        s1_adv;
    logic        wr_en;
    logic [ADDR_W-1:0] s1_addr;

    dbnc_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // unpack the input transfer
    always_comb begin
        in_sample.channel   = s_axis_tdata[CH_W-1:0];
        in_sample.pin_level = s_axis_tdata[CH_W];
        in_sample.adc_value = s_axis_tdata[CH_W+1 +: ADC_BITS];
        in_sample.in_range  = ({1'b0, in_sample.channel} < NUM_CH_W'(NUM_CHANNELS));
    end

    // handshake: update stage moves on when the output register is free or drains
    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !m_valid_reg || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_xfer) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    dbnc_state_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .rd_addr (in_sample.channel[ADDR_W-1:0]),
        .rd_data (ram_rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (new_state)
    );

    // forward the last write, which the memory read may have missed
    assign s1_addr   = s1_sample_reg.channel[ADDR_W-1:0];
    assign cur_state = (wb_valid_reg && (wb_addr_reg == s1_addr)) ? wb_data_reg : ram_rd_data;

    dbnc_update u_upd (
        .cfg       (cfg),
        .sample    (s1_sample_reg),
        .cur_state (cur_state),
        .new_state (new_state),
        .result    (upd_result)
    );

    assign wr_en = s1_adv && s1_sample_reg.in_range;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (wr_en) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_sample_reg <= in_sample;
        end
        if (s1_adv) begin
            m_result_reg <= upd_result;
        end
        if (wr_en) begin
            wb_addr_reg <= s1_addr;
            wb_data_reg <= new_state;
        end
    end

    // pack the result transfer
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_result_reg.count_value, m_result_reg.raw_level,
                            m_result_reg.filtered_level, m_result_reg.out_channel};

endmodule

/* hw/rtl/dbnc_checker.sv */
// port-level checker for the debouncer core, bound to the top level
// depends on dbnc_pkg for the stream widths

module dbnc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dbnc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import dbnc_pkg::*;

    // a stalled result holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input backpressure only comes from a full, stalled output
    a_bp_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output side can move");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:CH_W+2+CNT_W] == '0)
        else $error("result padding not zero");

endmodule

bind multichannel_input_debouncer_core dbnc_checker u_dbnc_checker (.*);
